// File: hw/rtl/mhpq_pkg.sv
package mhpq_pkg;

    // heap geometry
    localparam int CAPACITY = 64;
    localparam int ADDR_W   = $clog2(CAPACITY);
    localparam int CNT_W    = $clog2(CAPACITY + 1);
    localparam int KEY_W    = 32;

    // operation codes
    localparam logic [1:0] KIND_INSERT   = 2'd0;
    localparam logic [1:0] KIND_REMOVE   = 2'd1;
    localparam logic [1:0] KIND_CONTAINS = 2'd2;

    // status codes
    localparam logic [1:0] STATUS_OK    = 2'd0;
    localparam logic [1:0] STATUS_EMPTY = 2'd1;
    localparam logic [1:0] STATUS_FULL  = 2'd2;

    typedef struct packed {
        logic [1:0]              kind;
        logic signed [KEY_W-1:0] key_value;
    } in_item_t;

    typedef struct packed {
        logic [1:0]              status;
        logic                    found;
        logic signed [KEY_W-1:0] top_value;
        logic [6:0]              entry_count;
    } out_item_t;

endpackage

// File: hw/rtl/mhpq_ram.sv
module mhpq_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  logic                     aclk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    // one write port, one registered read port
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        rd_data <= mem[rd_addr];
    end

endmodule

// File: hw/rtl/max_heap_priority_queue_top.sv
// channel  | ports                       | direction | payload
// ---------+-----------------------------+-----------+------------------------------------
// input    | s_valid, s_ready, s_item    | in        | kind, key_value
// result   | m_valid, m_ready, m_item    | out       | status, found, top_value, entry_count
//
// One item at a time; s_ready is high only while the sequencer is idle.
// Insert climbs past each strictly smaller parent and writes the key into the hole;
// remove sifts the last entry down from the root, or ends at once for the last one;
// contains scans in order (one memory read per cycle); no-op and errors end at once.
// Reset (aresetn low, synchronous) empties the heap; the memory is not cleared.
// A result waiting on m_ready holds the sequencer in its final step.
module max_heap_priority_queue_top
    import mhpq_pkg::*;
(
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      s_valid,
    output logic      s_ready,
    input  in_item_t  s_item,
    output logic      m_valid,
    input  logic      m_ready,
    output out_item_t m_item
);

    localparam int CHILD_W = ADDR_W + 2;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_UP_CHK,
        ST_UP_CMP,
        ST_RM_RD,
        ST_RM_WAIT,
        ST_DN_CHK,
        ST_DN_L,
        ST_DN_R,
        ST_SCAN,
        ST_FIN
    } state_t;

    state_t                  state_reg, state_next;
    logic signed [KEY_W-1:0] key_reg, key_next;
    logic [ADDR_W-1:0]       pos_reg, pos_next;
    logic [CNT_W-1:0]        fill_reg, fill_next;
    logic signed [KEY_W-1:0] top_reg, top_next;
    logic [CNT_W-1:0]        idx_reg, idx_next;
    logic                    cmp_vld_reg, cmp_vld_next;
    logic signed [KEY_W-1:0] big_val_reg, big_val_next;
    logic [ADDR_W-1:0]       big_idx_reg, big_idx_next;
    logic [1:0]              status_reg, status_next;
    logic                    found_reg, found_next;
    logic                    m_valid_reg, m_valid_next;
    out_item_t               m_item_reg, m_item_next;

    logic                    wr_en;
    logic [ADDR_W-1:0]       wr_addr;
    logic [KEY_W-1:0]        wr_data;
    logic [ADDR_W-1:0]       rd_addr;
    logic [KEY_W-1:0]        rd_data;
    logic signed [KEY_W-1:0] rd_val;

    logic [CHILD_W-1:0]      left_idx;
    logic [CHILD_W-1:0]      right_idx;
    logic [CHILD_W-1:0]      fill_ext;
    logic [ADDR_W-1:0]       pos_m1;
    logic [ADDR_W-1:0]       parent_idx;
    logic signed [KEY_W-1:0] best_val;
    logic [ADDR_W-1:0]       best_idx;

    mhpq_ram #(
        .WIDTH(KEY_W),
        .DEPTH(CAPACITY)
    ) u_store (
        .aclk   (aclk),
        .wr_en  (wr_en),
        .wr_addr(wr_addr),
        .wr_data(wr_data),
        .rd_addr(rd_addr),
        .rd_data(rd_data)
    );

    assign rd_val     = $signed(rd_data);
    assign left_idx   = CHILD_W'({pos_reg, 1'b1});
    assign right_idx  = left_idx + CHILD_W'(1);
    assign fill_ext   = CHILD_W'(fill_reg);
    assign pos_m1     = pos_reg - ADDR_W'(1);
    assign parent_idx = ADDR_W'(pos_m1 >> 1);

    assign s_ready = (state_reg == ST_IDLE);
    assign m_valid = m_valid_reg;
    assign m_item  = m_item_reg;

    // larger child: left unless right is strictly larger
    always_comb begin
        best_val = big_val_reg;
        best_idx = big_idx_reg;
        if (state_reg == ST_DN_L) begin
            best_val = rd_val;
            best_idx = left_idx[ADDR_W-1:0];
        end else if (rd_val > big_val_reg) begin
            best_val = rd_val;
            best_idx = right_idx[ADDR_W-1:0];
        end
    end

    // sequencer next state
    always_comb begin
        state_next   = state_reg;
        key_next     = key_reg;
        pos_next     = pos_reg;
        fill_next    = fill_reg;
        top_next     = top_reg;
        idx_next     = idx_reg;
        cmp_vld_next = cmp_vld_reg;
        big_val_next = big_val_reg;
        big_idx_next = big_idx_reg;
        status_next  = status_reg;
        found_next   = found_reg;
        m_valid_next = m_valid_reg && !m_ready;
        m_item_next  = m_item_reg;
        wr_en        = 1'b0;
        wr_addr      = pos_reg;
        wr_data      = key_reg;
        rd_addr      = '0;

        case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    key_next    = s_item.key_value;
                    status_next = STATUS_OK;
                    found_next  = 1'b0;
                    state_next  = ST_FIN;
                    case (s_item.kind)
                        KIND_INSERT: begin
                            if (fill_reg >= CNT_W'(CAPACITY)) begin
                                status_next = STATUS_FULL;
                            end else begin
                                pos_next   = ADDR_W'(fill_reg);
                                fill_next  = fill_reg + CNT_W'(1);
                                state_next = ST_UP_CHK;
                            end
                        end
                        KIND_REMOVE: begin
                            if (fill_reg == '0) begin
                                status_next = STATUS_EMPTY;
                            end else begin
                                fill_next = fill_reg - CNT_W'(1);
                                if (fill_reg != CNT_W'(1)) begin
                                    state_next = ST_RM_RD;
                                end
                            end
                        end
                        KIND_CONTAINS: begin
                            idx_next     = '0;
                            cmp_vld_next = 1'b0;
                            state_next   = ST_SCAN;
                        end
                        default: begin
                            state_next = ST_FIN;
                        end
                    endcase
                end
            end

            // sift up: hole at pos, new key held in key_reg
            ST_UP_CHK: begin
                if (pos_reg == '0) begin
                    wr_en      = 1'b1;
                    state_next = ST_FIN;
                end else begin
                    rd_addr    = parent_idx;
                    state_next = ST_UP_CMP;
                end
            end

            ST_UP_CMP: begin
                wr_en = 1'b1;
                if (rd_val < key_reg) begin
                    wr_data    = rd_data;
                    pos_next   = parent_idx;
                    state_next = ST_UP_CHK;
                end else begin
                    state_next = ST_FIN;
                end
            end

            // fetch last entry, it becomes the moving key
            ST_RM_RD: begin
                rd_addr    = ADDR_W'(fill_reg);
                state_next = ST_RM_WAIT;
            end

            ST_RM_WAIT: begin
                key_next   = rd_val;
                pos_next   = '0;
                state_next = ST_DN_CHK;
            end

            // sift down: hole at pos
            ST_DN_CHK: begin
                if (left_idx >= fill_ext) begin
                    wr_en      = 1'b1;
                    state_next = ST_FIN;
                end else begin
                    rd_addr    = left_idx[ADDR_W-1:0];
                    state_next = ST_DN_L;
                end
            end

            ST_DN_L, ST_DN_R: begin
                if (state_reg == ST_DN_L && right_idx < fill_ext) begin
                    big_val_next = rd_val;
                    big_idx_next = left_idx[ADDR_W-1:0];
                    rd_addr      = right_idx[ADDR_W-1:0];
                    state_next   = ST_DN_R;
                end else begin
                    wr_en = 1'b1;
                    if (best_val > key_reg) begin
                        wr_data    = best_val;
                        pos_next   = best_idx;
                        state_next = ST_DN_CHK;
                    end else begin
                        state_next = ST_FIN;
                    end
                end
            end

            // linear search, one read issued per cycle
            ST_SCAN: begin
                if (cmp_vld_reg && rd_val == key_reg) begin
                    found_next = 1'b1;
                    state_next = ST_FIN;
                end else if (idx_reg < fill_reg) begin
                    rd_addr      = idx_reg[ADDR_W-1:0];
                    idx_next     = idx_reg + CNT_W'(1);
                    cmp_vld_next = 1'b1;
                end else begin
                    state_next = ST_FIN;
                end
            end

            // hand the result to the output register
            ST_FIN: begin
                if (!m_valid_reg || m_ready) begin
                    m_valid_next            = 1'b1;
                    m_item_next.status      = status_reg;
                    m_item_next.found       = found_reg;
                    m_item_next.top_value   = (fill_reg == '0) ? '0 : top_reg;
                    m_item_next.entry_count = 7'(fill_reg);
                    state_next              = ST_IDLE;
                end
            end

            default: begin
                state_next = ST_IDLE;
            end
        endcase

        // root copy follows every write to entry zero
        if (wr_en && wr_addr == '0) begin
            top_next = $signed(wr_data);
        end
    end

    // state and registered outputs
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            fill_reg    <= '0;
            m_valid_reg <= 1'b0;
            cmp_vld_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            fill_reg    <= fill_next;
            m_valid_reg <= m_valid_next;
            cmp_vld_reg <= cmp_vld_next;
        end
        key_reg     <= key_next;
        pos_reg     <= pos_next;
        top_reg     <= top_next;
        idx_reg     <= idx_next;
        big_val_reg <= big_val_next;
        big_idx_reg <= big_idx_next;
        status_reg  <= status_next;
        found_reg   <= found_next;
        m_item_reg  <= m_item_next;
    end

endmodule

// File: dv/tb_max_heap_priority_queue_top.sv
module tb_max_heap_priority_queue_top;
    import mhpq_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    // kind code the block treats as a no-op
    localparam logic [1:0] KIND_UNDEF = 2'd3;

    localparam logic signed [KEY_W-1:0] MAX_KEY = 32'sh7fff_ffff;
    localparam logic signed [KEY_W-1:0] MIN_KEY = 32'sh8000_0000;

    localparam int PHASES        = 4;
    localparam int PHASE_ITEMS   = 170;
    localparam int TAIL_CYCLES   = 100;
    localparam int REPORT_LIMIT  = 10;
    localparam int SEND_IDLE_PCT  [PHASES] = '{0, 71, 0, 24};
    localparam int RECV_STALL_PCT [PHASES] = '{0, 0, 71, 24};

    typedef enum int {
        BURST_FILL,
        BURST_DRAIN,
        BURST_MIX
    } burst_mode_t;

    // one opening row: operation, key, and a hand-written result where obvious
    typedef struct packed {
        logic [1:0]              kind;
        logic signed [KEY_W-1:0] key;
        logic                    typed;
        logic [1:0]              status;
        logic                    found;
        logic signed [KEY_W-1:0] top;
        logic [6:0]              count;
    } opening_row_t;

    localparam int OPENING_LEN = 22;
    localparam opening_row_t OPENING_ROWS [OPENING_LEN] = '{
        '{KIND_REMOVE,   32'sd0,  1'b1, STATUS_EMPTY, 1'b0, 32'sd0,  7'd0},
        '{KIND_CONTAINS, 32'sd0,  1'b1, STATUS_OK,    1'b0, 32'sd0,  7'd0},
        '{KIND_UNDEF,    32'sd5,  1'b1, STATUS_OK,    1'b0, 32'sd0,  7'd0},
        '{KIND_INSERT,   MAX_KEY, 1'b1, STATUS_OK,    1'b0, MAX_KEY, 7'd1},
        '{KIND_INSERT,   MIN_KEY, 1'b1, STATUS_OK,    1'b0, MAX_KEY, 7'd2},
        '{KIND_CONTAINS, MIN_KEY, 1'b1, STATUS_OK,    1'b1, MAX_KEY, 7'd2},
        '{KIND_CONTAINS, 32'sd0,  1'b1, STATUS_OK,    1'b0, MAX_KEY, 7'd2},
        '{KIND_REMOVE,   32'sd0,  1'b1, STATUS_OK,    1'b0, MIN_KEY, 7'd1},
        '{KIND_REMOVE,   32'sd0,  1'b1, STATUS_OK,    1'b0, 32'sd0,  7'd0},
        '{KIND_REMOVE,   32'sd0,  1'b1, STATUS_EMPTY, 1'b0, 32'sd0,  7'd0},
        '{KIND_INSERT,   32'sd5,  1'b1, STATUS_OK,    1'b0, 32'sd5,  7'd1},
        '{KIND_INSERT,   32'sd5,  1'b1, STATUS_OK,    1'b0, 32'sd5,  7'd2},
        '{KIND_INSERT,   32'sd7,  1'b1, STATUS_OK,    1'b0, 32'sd7,  7'd3},
        '{KIND_INSERT,   -32'sd1, 1'b1, STATUS_OK,    1'b0, 32'sd7,  7'd4},
        '{KIND_INSERT,   32'sd6,  1'b1, STATUS_OK,    1'b0, 32'sd7,  7'd5},
        '{KIND_UNDEF,    32'sd7,  1'b1, STATUS_OK,    1'b0, 32'sd7,  7'd5},
        '{KIND_CONTAINS, 32'sd6,  1'b1, STATUS_OK,    1'b1, 32'sd7,  7'd5},
        '{KIND_REMOVE,   32'sd0,  1'b0, STATUS_OK,    1'b0, 32'sd0,  7'd0},
        '{KIND_REMOVE,   MAX_KEY, 1'b0, STATUS_OK,    1'b0, 32'sd0,  7'd0},
        '{KIND_CONTAINS, 32'sd5,  1'b0, STATUS_OK,    1'b0, 32'sd0,  7'd0},
        '{KIND_INSERT,   MIN_KEY, 1'b0, STATUS_OK,    1'b0, 32'sd0,  7'd0},
        '{KIND_CONTAINS, -32'sd1, 1'b0, STATUS_OK,    1'b0, 32'sd0,  7'd0}
    };

    logic      aclk;
    logic      aresetn = 1'b0;
    logic      s_valid = 1'b0;
    logic      s_ready;
    in_item_t  s_item  = '0;
    logic      m_valid;
    logic      m_ready = 1'b0;
    out_item_t m_item;

    // shadow heap and results still owed by the block
    logic signed [KEY_W-1:0] heap_keys [CAPACITY];
    int                      heap_fill = 0;
    out_item_t               owed_results [$];

    int mismatch_count = 0;
    int items_sent     = 0;
    int send_idle_pct  = 0;
    int recv_stall_pct = 0;

    max_heap_priority_queue_top dut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_item  (s_item),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_item  (m_item)
    );

    // clock
    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    // run limit
    initial begin
        #5ms;
        $display("** max_heap_priority_queue_top: FAILED **");
        $finish;
    end

    // apply one operation to the shadow heap and return the result it gives
    function automatic out_item_t heap_apply(input in_item_t op);
        int                      pos;
        int                      parent;
        int                      left;
        int                      big;
        logic signed [KEY_W-1:0] held;
        out_item_t               res;
        res = '0;
        res.status = STATUS_OK;
        case (op.kind)
            KIND_INSERT: begin
                if (heap_fill >= CAPACITY) begin
                    res.status = STATUS_FULL;
                end else begin
                    heap_keys[heap_fill] = op.key_value;
                    pos = heap_fill;
                    heap_fill++;
                    // climb only past a strictly smaller parent
                    while (pos > 0) begin
                        parent = (pos - 1) / 2;
                        if (heap_keys[parent] >= heap_keys[pos])
                            break;
                        held = heap_keys[parent];
                        heap_keys[parent] = heap_keys[pos];
                        heap_keys[pos] = held;
                        pos = parent;
                    end
                end
            end
            KIND_REMOVE: begin
                if (heap_fill == 0) begin
                    res.status = STATUS_EMPTY;
                end else begin
                    heap_fill--;
                    heap_keys[0] = heap_keys[heap_fill];
                    pos = 0;
                    // sink toward the larger child, left on a tie
                    forever begin
                        left = 2 * pos + 1;
                        big = pos;
                        if (left < heap_fill && heap_keys[left] > heap_keys[big])
                            big = left;
                        if (left + 1 < heap_fill && heap_keys[left + 1] > heap_keys[big])
                            big = left + 1;
                        if (big == pos)
                            break;
                        held = heap_keys[big];
                        heap_keys[big] = heap_keys[pos];
                        heap_keys[pos] = held;
                        pos = big;
                    end
                end
            end
            KIND_CONTAINS: begin
                for (int i = 0; i < heap_fill; i++) begin
                    if (heap_keys[i] == op.key_value)
                        res.found = 1'b1;
                end
            end
            default: ;
        endcase
        res.top_value   = (heap_fill > 0) ? heap_keys[0] : '0;
        res.entry_count = 7'(heap_fill);
        return res;
    endfunction

    // keys: a narrow band for duplicates, extremes, stored keys, and full range
    function automatic logic signed [KEY_W-1:0] pick_key();
        logic signed [KEY_W-1:0] k;
        case ($urandom_range(9))
            0, 1, 2, 3: k = $signed(KEY_W'($urandom_range(16))) - 32'sd8;
            4: begin
                case ($urandom_range(3))
                    0:       k = MAX_KEY;
                    1:       k = MIN_KEY;
                    2:       k = 32'sd0;
                    default: k = -32'sd1;
                endcase
            end
            5, 6: k = (heap_fill > 0) ? heap_keys[$urandom_range(heap_fill - 1)]
                                      : $signed($urandom);
            default: k = $signed($urandom);
        endcase
        return k;
    endfunction

    // hold one item until taken, log its expected result, then maybe go idle
    task automatic send_item(input in_item_t op, input logic typed, input out_item_t typed_res);
        out_item_t predicted;
        s_item  <= op;
        s_valid <= 1'b1;
        do @(posedge aclk); while (!s_ready);
        predicted = heap_apply(op);
        owed_results.push_back(typed ? typed_res : predicted);
        items_sent++;
        if ($urandom_range(99) < send_idle_pct) begin
            s_valid <= 1'b0;
            do @(posedge aclk); while ($urandom_range(99) < send_idle_pct);
        end
    endtask

    task automatic send_kind(input logic [1:0] kind);
        in_item_t op;
        op.kind      = kind;
        op.key_value = pick_key();
        send_item(op, 1'b0, '0);
    endtask

    // hold off the sender until every owed result has come back
    task automatic wait_settled();
        s_valid <= 1'b0;
        do @(posedge aclk); while (owed_results.size() != 0);
    endtask

    // stimulus
    initial begin
        in_item_t    op;
        out_item_t   typed_res;
        burst_mode_t mode;
        int          burst;
        int          phase_end;
        int          pick;

        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // opening rows
        for (int r = 0; r < OPENING_LEN; r++) begin
            op.kind               = OPENING_ROWS[r].kind;
            op.key_value          = OPENING_ROWS[r].key;
            typed_res.status      = OPENING_ROWS[r].status;
            typed_res.found       = OPENING_ROWS[r].found;
            typed_res.top_value   = OPENING_ROWS[r].top;
            typed_res.entry_count = OPENING_ROWS[r].count;
            send_item(op, OPENING_ROWS[r].typed, typed_res);
        end
        wait_settled();

        // random bursts under each idling profile
        for (int phase = 0; phase < PHASES; phase++) begin
            send_idle_pct  = SEND_IDLE_PCT[phase];
            recv_stall_pct = RECV_STALL_PCT[phase];
            phase_end      = items_sent + PHASE_ITEMS;
            burst          = 0;
            while (items_sent < phase_end) begin
                if (burst == 0) begin
                    mode = BURST_FILL;
                end else begin
                    pick = $urandom_range(5);
                    mode = (pick == 0) ? BURST_FILL :
                           (pick == 1) ? BURST_DRAIN : BURST_MIX;
                end
                case (mode)
                    BURST_FILL: begin
                        // grow to capacity, then push past it
                        while (heap_fill < CAPACITY)
                            send_kind(($urandom_range(7) == 0) ? KIND_CONTAINS : KIND_INSERT);
                        repeat ($urandom_range(4, 1)) send_kind(KIND_INSERT);
                    end
                    BURST_DRAIN: begin
                        // empty out, then remove past empty
                        while (heap_fill > 0)
                            send_kind(($urandom_range(7) == 0) ? KIND_CONTAINS : KIND_REMOVE);
                        repeat ($urandom_range(3, 1)) send_kind(KIND_REMOVE);
                    end
                    default: begin
                        repeat ($urandom_range(60, 20)) begin
                            pick = $urandom_range(99);
                            if (pick < 40)
                                send_kind(KIND_INSERT);
                            else if (pick < 75)
                                send_kind(KIND_REMOVE);
                            else if (pick < 97)
                                send_kind(KIND_CONTAINS);
                            else
                                send_kind(KIND_UNDEF);
                        end
                    end
                endcase
                burst++;
            end
            wait_settled();
        end

        // tail: let any stray result show up
        repeat (TAIL_CYCLES) @(posedge aclk);
        if (mismatch_count == 0 && owed_results.size() == 0) begin
            $display("** max_heap_priority_queue_top: PASSED **");
        end else begin
            $display("** max_heap_priority_queue_top: FAILED **");
        end
        $finish;
    end

    // result checking and receiver stalls
    always @(posedge aclk) begin : result_check
        out_item_t want;
        if (aresetn && m_valid && m_ready) begin
            if (owed_results.size() == 0) begin
                mismatch_count++;
                if (mismatch_count <= REPORT_LIMIT)
                    $display("%t: result item with nothing owed: status=%0d found=%0d",
                             $realtime, m_item.status, m_item.found,
                             " top=%0d count=%0d", m_item.top_value,
                             m_item.entry_count);
            end else begin
                want = owed_results.pop_front();
                if (m_item.status !== want.status || m_item.found !== want.found ||
                    m_item.top_value !== want.top_value ||
                    m_item.entry_count !== want.entry_count) begin
                    mismatch_count++;
                    if (mismatch_count <= REPORT_LIMIT) begin
                        $display("%t: mismatch exp status=%0d found=%0d top=%0d count=%0d",
                                 $realtime, want.status, want.found, want.top_value,
                                 want.entry_count);
                        $display("%t: mismatch got status=%0d found=%0d top=%0d count=%0d",
                                 $realtime, m_item.status, m_item.found,
                                 m_item.top_value, m_item.entry_count);
                    end
                end
            end
        end
        m_ready <= ($urandom_range(99) >= recv_stall_pct);
    end

endmodule
